/* hdl/glh_pkg.sv */
package glh_pkg;

  localparam int MAX_PIXELS = 4194304;
  localparam int BIN_COUNT  = 256;

  localparam int OP_W    = 2;
  localparam int PIX_W   = 8;
  localparam int COUNT_W = 23;
  localparam int LEVELS  = 256;
  localparam int ADDR_W  = $clog2(LEVELS);
  localparam int RANGE_W = ADDR_W + 1;

  localparam int COUNT_MAX = (1 << COUNT_W) - 1;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT =
    (MAX_PIXELS > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(MAX_PIXELS);
  localparam logic [RANGE_W-1:0] BINS_USED = RANGE_W'(BIN_COUNT);
  localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(LEVELS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_ACCUM = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

endpackage

/* hdl/glh_ram.sv */
module glh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/gray_level_histogram.sv */
// Gray-level histogram with peak tracking.
// The input channel (in_valid, in_stall) carries an operation with a pixel
// and a bin index. An accumulate transfer adds one to the bin of its pixel,
// saturating at the count limit, and updates the peak; it gives no result.
// A read transfer gives one result transfer on the output channel
// (out_valid, out_stall) with the bin's count and the current peak; the
// result is registered in the output register after the bin store read.
// Accumulates and reads are accepted one per cycle while in_stall is low: the
// bin store is read in the cycle of acceptance and written back in the next
// cycle, and a write to the same bin is forwarded to the next item.
// A clear transfer zeroes the peak and starts a sweep that writes zero to
// every entry of the bin store, one entry per cycle; in_stall is high from
// the cycle after the clear until the sweep ends.
// After reset the same sweep runs before the first transfer is accepted.
// When the receiver stalls with a result waiting, a second read that reaches
// the output stage holds there and in_stall rises until the result leaves.
module gray_level_histogram
  import glh_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [PIX_W-1:0]   in_pixel,
  input  logic [ADDR_W-1:0]  in_bin_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COUNT_W-1:0] out_bin_count,
  output logic [COUNT_W-1:0] out_peak_count
);

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;

  logic               s2_valid_r;
  logic [OP_W-1:0]    s2_op_r;
  logic [ADDR_W-1:0]  s2_addr_r;

  logic               fwd_valid_r;
  logic [ADDR_W-1:0]  fwd_addr_r;
  logic [COUNT_W-1:0] fwd_data_r;

  logic [COUNT_W-1:0] peak_r;
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_bin_count_r;
  logic [COUNT_W-1:0] out_peak_count_r;

  logic               in_accept;
  logic               blocked;
  logic               s2_acc;
  logic               s2_read;
  logic               s2_clear;
  logic               s2_in_range;
  logic [ADDR_W-1:0]  rd_addr;
  logic [COUNT_W-1:0] rd_data;
  logic [COUNT_W-1:0] cur_count;
  logic [COUNT_W-1:0] new_count;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;

  assign s2_acc      = s2_valid_r && (s2_op_r == OP_ACCUM);
  assign s2_read     = s2_valid_r && (s2_op_r == OP_READ);
  assign s2_clear    = s2_valid_r && (s2_op_r == OP_CLEAR);
  assign s2_in_range = {1'b0, s2_addr_r} < BINS_USED;
  assign blocked     = s2_read && out_valid_r && out_stall;
  assign in_accept   = in_valid && !in_stall;
  assign rd_addr     = (in_operation == OP_READ) ? in_bin_index : in_pixel;

  assign cur_count = (fwd_valid_r && (fwd_addr_r == s2_addr_r)) ? fwd_data_r : rd_data;
  assign new_count = (cur_count < COUNT_LIMIT) ? cur_count + COUNT_W'(1) : cur_count;

  glh_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(LEVELS)
  ) u_bins (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (in_accept),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        clr_addr_nxt = '0;
        if (s2_clear) begin
          state_nxt = ST_CLEAR;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = s2_addr_r;
    ram_wdata = new_count;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      ST_RUN: begin
        in_stall = s2_clear || blocked;
        ram_we   = s2_acc && s2_in_range;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      s2_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (s2_read && !blocked) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_CLEAR) begin
        s2_valid_r  <= 1'b0;
        fwd_valid_r <= 1'b0;
      end else if (!blocked) begin
        s2_valid_r  <= in_accept;
        fwd_valid_r <= ram_we;
        if (s2_clear) begin
          peak_r <= '0;
        end else if (ram_we && (new_count > peak_r)) begin
          peak_r <= new_count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s2_op_r   <= in_operation;
      s2_addr_r <= rd_addr;
    end
    if (!blocked) begin
      fwd_addr_r <= s2_addr_r;
      fwd_data_r <= new_count;
    end
    if (s2_read && !blocked) begin
      out_bin_count_r  <= s2_in_range ? cur_count : '0;
      out_peak_count_r <= peak_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bin_count  = out_bin_count_r;
  assign out_peak_count = out_peak_count_r;

endmodule

/* tb/sv/gray_level_histogram_tb.sv */
module gray_level_histogram_tb;
  import glh_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_LEN       = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int RANDOM_ITEMS   = 320;
  localparam int REPORT_LIMIT   = 10;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN,
    STALL_HEAVY
  } stall_mode_t;

  typedef struct packed {
    logic [COUNT_W-1:0] bin_count;
    logic [COUNT_W-1:0] peak_count;
  } bin_read_t;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic [OP_W-1:0]    in_operation = OP_UNUSED;
  logic [PIX_W-1:0]   in_pixel     = '0;
  logic [ADDR_W-1:0]  in_bin_index = '0;
  logic               out_stall    = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [COUNT_W-1:0] out_bin_count;
  logic [COUNT_W-1:0] out_peak_count;

  logic [COUNT_W-1:0] hist_bins [LEVELS];
  logic [COUNT_W-1:0] hist_peak;
  bin_read_t          expected_reads [$];

  int          mismatches    = 0;
  int          idle_cycles   = 0;
  int          burst_left    = 0;
  bit          pace_on       = 1'b0;
  stall_mode_t stall_mode    = STALL_NONE;
  int          hold_requests = 0;
  int          holds_done    = 0;
  int          hold_left     = 0;
  int          pattern_phase = 0;

  gray_level_histogram uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_pixel       (in_pixel),
    .in_bin_index   (in_bin_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bin_count  (out_bin_count),
    .out_peak_count (out_peak_count)
  );

  always #1 clk = ~clk;

  function automatic void clear_histogram();
    for (int i = 0; i < LEVELS; i++) hist_bins[i] = '0;
    hist_peak = '0;
  endfunction

  function automatic void apply_histogram_op(logic [OP_W-1:0] op, logic [PIX_W-1:0] pix,
                                             logic [ADDR_W-1:0] sel);
    logic [COUNT_W-1:0] cnt;
    bin_read_t          rd;
    case (op)
      OP_ACCUM: begin
        if (pix < BINS_USED) begin
          cnt = hist_bins[pix];
          if (cnt < COUNT_LIMIT) cnt = cnt + COUNT_W'(1);
          hist_bins[pix] = cnt;
          if (cnt > hist_peak) hist_peak = cnt;
        end
      end
      OP_READ: begin
        rd.bin_count  = (sel < BINS_USED) ? hist_bins[sel] : '0;
        rd.peak_count = hist_peak;
        expected_reads.push_back(rd);
      end
      OP_CLEAR: begin
        clear_histogram();
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void note_mismatch(string what, logic [COUNT_W-1:0] want,
                                        logic [COUNT_W-1:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("MISMATCH %s: expected %0d, actual %0d", what, want, got);
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, logic [PIX_W-1:0] pix,
                           logic [ADDR_W-1:0] sel);
    int gap;
    if (pace_on && burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid     <= 1'b1;
    in_operation <= op;
    in_pixel     <= pix;
    in_bin_index <= sel;
    do @(posedge clk); while (in_stall !== 1'b0);
    apply_histogram_op(op, pix, sel);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_contents();
    pace_on    = 1'b0;
    stall_mode = STALL_NONE;
    send_item(OP_READ, 8'h00, 8'h00);
    send_item(OP_READ, 8'hFF, 8'hFF);
    send_item(OP_UNUSED, 8'h00, 8'h00);
    send_item(OP_UNUSED, 8'hFF, 8'hFF);
    send_item(OP_READ, 8'h5A, 8'h80);
    stop_sending();
  endtask

  task automatic test_accumulate_and_read();
    pace_on    = 1'b0;
    stall_mode = STALL_RANDOM;
    send_item(OP_ACCUM, 8'h00, 8'hFF);
    send_item(OP_ACCUM, 8'hFF, 8'h00);
    send_item(OP_ACCUM, 8'hFF, 8'hAA);
    send_item(OP_ACCUM, 8'hAA, 8'h55);
    send_item(OP_ACCUM, 8'h55, 8'hAA);
    send_item(OP_READ, 8'hFF, 8'h00);
    send_item(OP_READ, 8'h00, 8'hFF);
    // Back-to-back updates of one bin, read at once, exercise the write forwarding.
    send_item(OP_ACCUM, 8'h07, 8'h00);
    send_item(OP_ACCUM, 8'h07, 8'h00);
    send_item(OP_ACCUM, 8'h07, 8'h00);
    send_item(OP_READ, 8'h00, 8'h07);
    send_item(OP_READ, 8'h00, 8'hAA);
    stop_sending();
  endtask

  task automatic test_clear();
    pace_on    = 1'b0;
    stall_mode = STALL_PATTERN;
    send_item(OP_CLEAR, 8'hFF, 8'hFF);
    send_item(OP_READ, 8'h00, 8'h07);
    send_item(OP_READ, 8'h00, 8'hFF);
    send_item(OP_ACCUM, 8'h00, 8'h00);
    send_item(OP_READ, 8'h00, 8'h00);
    send_item(OP_CLEAR, 8'h00, 8'h00);
    send_item(OP_READ, 8'hFF, 8'h00);
    stop_sending();
  endtask

  task automatic test_output_backpressure();
    logic [PIX_W-1:0] pix;
    pace_on    = 1'b0;
    stall_mode = STALL_NONE;
    hold_requests++;
    for (int i = 0; i < 40; i++) begin
      pix = PIX_W'($urandom_range(0, 3));
      if (i % 3 == 0) send_item(OP_ACCUM, pix, 8'h00);
      else send_item(OP_READ, 8'h00, pix);
    end
    stop_sending();
  endtask

  task automatic test_random_traffic();
    int                sent;
    int                pick;
    logic [OP_W-1:0]   op;
    logic [PIX_W-1:0]  pix;
    logic [ADDR_W-1:0] sel;
    logic [PIX_W-1:0]  hot [4];
    for (int i = 0; i < 4; i++) hot[i] = PIX_W'($urandom_range(0, 255));
    sent    = 0;
    pace_on = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 100 == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        pace_on    = (sent != 200);
      end
      pix  = $urandom_range(0, 1) ? hot[$urandom_range(0, 3)] : PIX_W'($urandom_range(0, 255));
      sel  = $urandom_range(0, 1) ? hot[$urandom_range(0, 3)] : ADDR_W'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 55) op = OP_ACCUM;
      else if (pick < 94) op = OP_READ;
      else if (pick < 95) op = OP_CLEAR;
      else op = OP_UNUSED;
      send_item(op, pix, sel);
      if (op != OP_UNUSED) sent++;
    end
    stop_sending();
  endtask

  initial begin
    clear_histogram();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_contents();
    test_accumulate_and_read();
    test_clear();
    test_output_backpressure();
    test_random_traffic();
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_reads.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // The receiver either holds off for a long stretch on request or stalls by its mode.
  always @(posedge clk) begin
    pattern_phase <= pattern_phase + 1;
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_requests) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_LEN - 1;
      holds_done <= holds_done + 1;
    end else begin
      case (stall_mode)
        STALL_NONE:    out_stall <= 1'b0;
        STALL_RANDOM:  out_stall <= ($urandom_range(0, 3) == 0);
        STALL_PATTERN: out_stall <= ((pattern_phase % 11) < 4);
        default:       out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    bin_read_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_reads.size() == 0) begin
        note_mismatch("result transfer with nothing expected, bin_count", '0, out_bin_count);
      end else begin
        want = expected_reads.pop_front();
        if (out_bin_count !== want.bin_count)
          note_mismatch("bin_count", want.bin_count, out_bin_count);
        if (out_peak_count !== want.peak_count)
          note_mismatch("peak_count", want.peak_count, out_peak_count);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule

/* gray_level_histogram.f */
hdl/glh_pkg.sv
hdl/glh_ram.sv
hdl/gray_level_histogram.sv
tb/sv/gray_level_histogram_tb.sv
